>>> design/assert_macros.svh
// Assertion macros shared by the block matcher RTL.
// Needs a clock and an active-low reset in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("block matcher: implication check failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("block matcher: next-cycle check failed");

// condition must never hold
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("block matcher: forbidden condition seen");

`endif

>>> design/ssdbm_pkg.sv
// Package for the SSD block matcher: widths, codes, state enum and the
// command/status structs between controller and datapath. No dependencies.
package ssdbm_pkg;

	localparam int MAX_BLOCKS   = 1024;
	localparam int BLOCK_PIXELS = 16;

	localparam int BLK_W  = $clog2(MAX_BLOCKS);
	localparam int PIX_W  = $clog2(BLOCK_PIXELS);
	localparam int ADDR_W = BLK_W + PIX_W;
	localparam int VAL_W  = 8;
	localparam int SQ_W   = 2 * VAL_W;
	localparam int SSD_W  = 20;
	localparam int TOT_W  = 40;
	localparam int CFG_W  = 11;

	localparam logic [CFG_W-1:0] BLOCKS_RESET = CFG_W'(MAX_BLOCKS);
	localparam logic [PIX_W-1:0] PIX_LAST     = PIX_W'(BLOCK_PIXELS - 1);
	localparam logic [BLK_W-1:0] BLK_LAST     = BLK_W'(MAX_BLOCKS - 1);
	localparam logic [TOT_W-1:0] TOT_MAX      = {TOT_W{1'b1}};
	localparam logic [SSD_W-1:0] SSD_MAX      =
		SSD_W'(BLOCK_PIXELS * ((2**VAL_W - 1) ** 2));

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic             kind;
		logic [BLK_W-1:0] blk;
		logic [PIX_W-1:0] pos;
		logic [VAL_W-1:0] val;
	} pix_t;

	typedef struct packed {
		logic wr_ref;
		logic wr_query;
		logic start;
		logic issue;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic issue_last;
		logic search_done;
	} stat_t;

endpackage

>>> design/ssdbm_ifs.sv
// Valid/ready channel interfaces for pixel words in and match words out.
// Depends on ssdbm_pkg for the field widths.
interface ssdbm_in_if import ssdbm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [BLK_W-1:0] block_number;
	logic [PIX_W-1:0] pixel_position;
	logic [VAL_W-1:0] pixel_value;

	modport source (output valid, kind, block_number, pixel_position, pixel_value,
		input ready);
	modport sink (input valid, kind, block_number, pixel_position, pixel_value,
		output ready);
endinterface

interface ssdbm_out_if import ssdbm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] best_index;
	logic [SSD_W-1:0] best_ssd;
	logic [TOT_W-1:0] total_ssd;

	modport source (output valid, best_index, best_ssd, total_ssd, input ready);
	modport sink (input valid, best_index, best_ssd, total_ssd, output ready);
endinterface

>>> design/ssdbm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ssdbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/ssdbm_ctrl.sv
// Controller FSM: input handshake, search sequencing and result publishing.
// Depends on ssdbm_pkg.
module ssdbm_ctrl import ssdbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	input  logic [PIX_W-1:0] in_pos,
	input  logic             out_ready,
	input  stat_t            stat,
	output logic             in_ready,
	output logic             out_valid,
	output cmd_t             cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_acc) begin
					cmd.wr_ref   = (in_kind == KIND_LOAD);
					cmd.wr_query = (in_kind == KIND_QUERY);
					if (in_kind == KIND_QUERY && in_pos == PIX_LAST) begin
						cmd.start = 1'b1;
						state_d   = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				cmd.issue = 1'b1;
				if (stat.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.search_done) begin
					state_d = ST_PUBLISH;
				end
			end
			ST_PUBLISH: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> design/ssdbm_dp.sv
// Datapath: reference RAM, query registers, SSD pipeline, best tracking,
// saturating total and output registers. Depends on ssdbm_pkg, ssdbm_ram.
module ssdbm_dp import ssdbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  pix_t             word,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output stat_t            stat,
	output logic [BLK_W-1:0] best_index,
	output logic [SSD_W-1:0] best_ssd,
	output logic [TOT_W-1:0] total_ssd
);

	logic [BLK_W-1:0] last_blk_q;
	logic [VAL_W-1:0] query_q [BLOCK_PIXELS];
	logic [BLK_W-1:0] blk_cnt_q;
	logic [PIX_W-1:0] pix_cnt_q;
	logic [VAL_W-1:0] ref_pix;

	logic             v_s1, v_s2;
	logic [PIX_W-1:0] pix_s1, pix_s2;
	logic [BLK_W-1:0] blk_s1, blk_s2;
	logic             lastblk_s1, lastblk_s2;
	logic [VAL_W-1:0] q_s1;
	logic [SQ_W-1:0]  sq_s2;
	logic [VAL_W-1:0] adiff;

	logic [SSD_W-1:0] acc_q, blk_sum;
	logic [SSD_W-1:0] best_q;
	logic [BLK_W-1:0] best_idx_q;
	logic             done_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W:0]   tot_sum;
	logic [BLK_W-1:0] out_idx_q;
	logic [SSD_W-1:0] out_ssd_q;

	// clamp block count: zero searches one block, above max searches all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_blk_q <= BLOCKS_RESET > CFG_W'(MAX_BLOCKS) ? BLK_LAST
				: BLK_W'(BLOCKS_RESET - 1'b1);
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				last_blk_q <= '0;
			end else if (cfg_data > CFG_W'(MAX_BLOCKS)) begin
				last_blk_q <= BLK_LAST;
			end else begin
				last_blk_q <= BLK_W'(cfg_data - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_query) begin
			query_q[word.pos] <= word.val;
		end
	end

	ssdbm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_BLOCKS * BLOCK_PIXELS)
	) u_ref_ram (
		.clk   (clk),
		.we    (cmd.wr_ref),
		.waddr ({word.blk, word.pos}),
		.wdata (word.val),
		.re    (cmd.issue),
		.raddr ({blk_cnt_q, pix_cnt_q}),
		.rdata (ref_pix)
	);

	// read address walk, block-major
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			blk_cnt_q <= '0;
			pix_cnt_q <= '0;
		end else if (cmd.issue) begin
			pix_cnt_q <= pix_cnt_q + 1'b1;
			if (pix_cnt_q == PIX_LAST) begin
				blk_cnt_q <= blk_cnt_q + 1'b1;
			end
		end
	end

	assign stat.issue_last  = (blk_cnt_q == last_blk_q) && (pix_cnt_q == PIX_LAST);
	assign stat.search_done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			done_q <= v_s2 && (pix_s2 == PIX_LAST) && lastblk_s2;
		end
	end

	// s1: RAM data lands, query pixel alongside
	always_ff @(posedge clk) begin
		pix_s1     <= pix_cnt_q;
		blk_s1     <= blk_cnt_q;
		lastblk_s1 <= (blk_cnt_q == last_blk_q);
		q_s1       <= query_q[pix_cnt_q];
	end

	assign adiff = (q_s1 >= ref_pix) ? (q_s1 - ref_pix) : (ref_pix - q_s1);

	// s2: squared difference
	always_ff @(posedge clk) begin
		pix_s2     <= pix_s1;
		blk_s2     <= blk_s1;
		lastblk_s2 <= lastblk_s1;
		sq_s2      <= adiff * adiff;
	end

	assign blk_sum = ((pix_s2 == '0) ? '0 : acc_q) + SSD_W'(sq_s2);

	// per-block accumulate; strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= blk_sum;
			if (pix_s2 == PIX_LAST && (blk_s2 == '0 || blk_sum < best_q)) begin
				best_q     <= blk_sum;
				best_idx_q <= blk_s2;
			end
		end
	end

	assign tot_sum = {1'b0, total_q} + (TOT_W + 1)'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.publish) begin
			total_q <= tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_idx_q <= best_idx_q;
			out_ssd_q <= best_q;
		end
	end

	assign best_index = out_idx_q;
	assign best_ssd   = out_ssd_q;
	assign total_ssd  = total_q;

endmodule

>>> design/block_ssd_best_match_search.sv
// Top level of the full-search 4x4 SSD block matcher.
// Depends on ssdbm_pkg, ssdbm_ifs, ssdbm_ctrl, ssdbm_dp, assert_macros.svh.
//
// Use:
//  - pixel channel (valid/ready): each word is a reference load (kind 0,
//    written at block_number/pixel_position) or a query pixel (kind 1).
//    Loads and query pixels other than the last raster position are
//    taken whenever idle and give no result.
//  - the query pixel at the last position starts a search over blocks
//    0 .. blocks_in_use-1 (zero means one block, above the store size means
//    all of it). pixel.ready stays low during the search.
//  - search: one reference pixel per cycle through the single read
//    port of the reference RAM, followed by pipeline drain and publish.
//  - result channel: one word per search carrying best index (lowest on a
//    tie), its SSD and the saturating running total of best SSDs.
//  - the result sits in an output register; loads and new queries are
//    taken while it waits. A finished search holds in its publish step
//    until the previous result has been taken.
//  - cfg_we/cfg_data write blocks_in_use; write only while idle.
//  - reset: running total cleared, blocks_in_use back to 1024. The
//    reference store and query are not cleared; read them only once written.
`include "assert_macros.svh"

module block_ssd_best_match_search import ssdbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	ssdbm_in_if.sink         pixel,
	ssdbm_out_if.source      result
);

	cmd_t  cmd;
	stat_t stat;
	pix_t  word;

	assign word.kind = pixel.kind;
	assign word.blk  = pixel.block_number;
	assign word.pos  = pixel.pixel_position;
	assign word.val  = pixel.pixel_value;

	ssdbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_kind   (pixel.kind),
		.in_pos    (pixel.pixel_position),
		.out_ready (result.ready),
		.stat      (stat),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	ssdbm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.word       (word),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.stat       (stat),
		.best_index (result.best_index),
		.best_ssd   (result.best_ssd),
		.total_ssd  (result.total_ssd)
	);

	// search start blocks the input on the following cycle
	`ASSERT_NEXT(a_busy_after_start, clk, arst_n, cmd.start, !pixel.ready)
	// RAM write port and read walk never overlap
	`ASSERT_NEVER(a_no_write_in_search, clk, arst_n, cmd.wr_ref && cmd.issue)
	// a reported SSD cannot exceed sixteen full-scale squares
	`ASSERT_IMPLIES(a_ssd_bound, clk, arst_n, result.valid, result.best_ssd <= SSD_MAX)
	// running total includes the SSD it reports (saturation keeps this)
	`ASSERT_IMPLIES(a_total_covers, clk, arst_n, result.valid,
		result.total_ssd >= TOT_W'(result.best_ssd))

endmodule
